/* rtl/core/hrbp_pkg.sv */
// shared types, character codes and per-byte helper functions of the request parser
package hrbp_pkg;

  localparam int unsigned RQ_DEPTH = 8;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_PATH    = 4'd1,
    PH_QUERY   = 4'd2,
    PH_VERSION = 4'd3,
    PH_LSTART  = 4'd4,
    PH_NAME    = 4'd5,
    PH_VSKIP   = 4'd6,
    PH_VALUE   = 4'd7,
    PH_BODY    = 4'd8,
    PH_REJECT  = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    K_METHOD  = 4'd0,
    K_PATH    = 4'd1,
    K_QSTART  = 4'd2,
    K_QUERY   = 4'd3,
    K_VERSION = 4'd4,
    K_NAME    = 4'd5,
    K_COLON   = 4'd6,
    K_SPACE   = 4'd7,
    K_VALUE   = 4'd8,
    K_LINEEND = 4'd9,
    K_BODY    = 4'd10,
    K_END     = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CRLF  = 2'd1,
    ST_NO_SP_M  = 2'd2,
    ST_NO_SP_P  = 2'd3
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic        cr_pending;
    logic        colon_seen;
    logic [1:0]  error_code;
    logic        line_open;
  } pstate_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  raw_byte;
    logic [7:0]  lowered_byte;
    logic        flag;
    logic [1:0]  status;
    logic        run_last;
  } res_t;

  typedef struct packed {
    pstate_t     st;
    logic        vld;
    kind_t       kind;
  } ord_t;

  localparam pstate_t PSTATE_RST = '{
    phase: PH_METHOD, cr_pending: 1'b0, colon_seen: 1'b0,
    error_code: 2'd0, line_open: 1'b0
  };

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UC_A && b <= CH_UC_Z) r = b | CASE_BIT;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [7:0] raw,
                                  input logic flag, input logic [1:0] status);
    res_t r;
    r.kind         = k;
    r.raw_byte     = raw;
    r.lowered_byte = to_lower(raw);
    r.flag         = flag;
    r.status       = status;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // classify one byte in the current phase
  function automatic ord_t ordinary(input pstate_t s, input logic [7:0] b);
    ord_t o;
    o.st   = s;
    o.vld  = 1'b1;
    o.kind = K_BODY;
    unique case (s.phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          o.kind = K_SPACE;
          o.st.phase = PH_PATH;
        end else begin
          o.kind = K_METHOD;
        end
      end
      PH_PATH: begin
        priority if (b == CH_SP) begin
          o.kind = K_SPACE;
          o.st.phase = PH_VERSION;
        end else if (b == CH_QM) begin
          o.kind = K_QSTART;
          o.st.phase = PH_QUERY;
        end else begin
          o.kind = K_PATH;
        end
      end
      PH_QUERY: begin
        if (b == CH_SP) begin
          o.kind = K_SPACE;
          o.st.phase = PH_VERSION;
        end else begin
          o.kind = K_QUERY;
        end
      end
      PH_VERSION: o.kind = K_VERSION;
      PH_LSTART, PH_NAME: begin
        o.st.line_open = 1'b1;
        if (b == CH_COLON) begin
          o.kind = K_COLON;
          o.st.colon_seen = 1'b1;
          o.st.phase = PH_VSKIP;
        end else begin
          o.kind = K_NAME;
          o.st.phase = PH_NAME;
        end
      end
      PH_VSKIP: begin
        o.st.line_open = 1'b1;
        if (is_ws(b)) begin
          o.kind = K_SPACE;
        end else begin
          o.kind = K_VALUE;
          o.st.phase = PH_VALUE;
        end
      end
      PH_VALUE: o.kind = K_VALUE;
      PH_BODY:  o.kind = K_BODY;
      default:  o.vld = 1'b0;
    endcase
    return o;
  endfunction

endpackage

/* rtl/core/hrbp_if.sv */
// valid/ready channel interfaces for request bytes and classified results
interface hrbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface hrbp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] raw_byte;
  logic [7:0] lowered_byte;
  logic       flag;
  logic [1:0] status;
  logic       run_last;

  modport source (output valid, kind, raw_byte, lowered_byte, flag, status, run_last,
                  input ready);
  modport sink (input valid, kind, raw_byte, lowered_byte, flag, status, run_last,
                output ready);
endinterface

/* rtl/core/hrbp_step.sv */
// parser state register and per-byte classification into up to three results
module hrbp_step
  import hrbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic [1:0] push_cnt,
  output res_t       push_res [3]
);

  pstate_t st_r, st_nxt;
  res_t    slot [3];
  logic [2:0] sv;
  logic [1:0] n;
  ord_t    o_cr, o_b;
  pstate_t s;
  logic    consumed;
  logic [1:0] end_status;
  logic    end_open;

  always_comb begin
    s          = st_r;
    sv         = '0;
    consumed   = 1'b0;
    end_status = ST_OK;
    end_open   = 1'b0;
    o_cr       = '0;
    o_b        = '0;
    slot[0]    = mk_res(K_LINEEND, '0, 1'b0, ST_OK);
    slot[1]    = mk_res(K_BODY, data_byte, 1'b0, ST_OK);
    slot[2]    = mk_res(K_END, '0, 1'b0, ST_OK);

    // held cr: either closes a line or becomes an ordinary byte
    if (s.cr_pending) begin
      s.cr_pending = 1'b0;
      if (data_byte == CH_LF) begin
        consumed = 1'b1;
        sv[0]    = 1'b1;
        slot[0]  = mk_res(K_LINEEND, '0, s.colon_seen, ST_OK);
        unique case (s.phase)
          PH_METHOD: begin
            s.error_code = ST_NO_SP_M;
            s.phase      = PH_REJECT;
          end
          PH_PATH, PH_QUERY: begin
            s.error_code = ST_NO_SP_P;
            s.phase      = PH_REJECT;
          end
          PH_VERSION: s.phase = PH_LSTART;
          PH_LSTART:  s.phase = PH_BODY;
          default: begin
            s.phase      = PH_LSTART;
            s.colon_seen = 1'b0;
            s.line_open  = 1'b0;
          end
        endcase
      end else begin
        o_cr    = ordinary(s, CH_CR);
        s       = o_cr.st;
        sv[0]   = o_cr.vld;
        slot[0] = mk_res(o_cr.kind, CH_CR, 1'b0, ST_OK);
      end
    end

    if (!consumed) begin
      if (data_byte == CH_CR && s.phase < PH_BODY && !last_byte) begin
        s.cr_pending = 1'b1;
      end else begin
        o_b     = ordinary(s, data_byte);
        s       = o_b.st;
        sv[1]   = o_b.vld;
        slot[1] = mk_res(o_b.kind, data_byte, 1'b0, ST_OK);
      end
    end

    if (last_byte) begin
      priority if (s.phase <= PH_VERSION) begin
        end_status = ST_NO_CRLF;
      end else if (s.phase >= PH_REJECT) begin
        end_status = s.error_code;
      end else if (s.phase >= PH_LSTART && s.phase <= PH_VALUE) begin
        end_open = s.line_open;
      end else begin
        end_open = 1'b0;
      end
      sv[2]   = 1'b1;
      slot[2] = mk_res(K_END, '0, end_open, end_status);
      s       = PSTATE_RST;
    end

    st_nxt = s;
  end

  // pack the valid slots in order and mark the last one
  always_comb begin
    n = '0;
    for (int k = 0; k < 3; k++) begin
      push_res[k] = slot[2];
    end
    for (int k = 0; k < 3; k++) begin
      if (sv[k]) begin
        push_res[n] = slot[k];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) push_res[n - 2'd1].run_last = 1'b1;
    push_cnt = acc ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RST;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/core/hrbp_rq.sv */
// result queue: takes up to three results a cycle, hands out one per beat
module hrbp_rq
  import hrbp_pkg::*;
#(
  parameter int unsigned DEPTH = RQ_DEPTH
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  res_t       push_res [3],
  input  logic       pop,
  output logic       not_empty,
  output logic       has_room,
  output res_t       head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  // room for a full three-result burst
  assign has_room  = (cnt_r <= CW'(DEPTH - 3));
  assign head      = mem[rp_r];
  assign cnt_nxt   = cnt_r + CW'(push_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_cnt) mem[wp_r + AW'(k)] <= push_res[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push_cnt);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/http_request_byte_parser_top.sv */
// top level of the http request byte parser
//
//  channel  | dir | beat payload
//  in_ch    | in  | data_byte[7:0], last_byte
//  out_ch   | out | kind[3:0], raw_byte[7:0], lowered_byte[7:0], flag, status[1:0], run_last
//
// a byte is classified in the cycle it is accepted and its results land in the result
// queue at the next edge; the first result can leave in the cycle after acceptance.
// each byte gives zero to three results and the output drains one per beat, so a
// stream of single-result bytes runs at one byte per cycle while out_ch.ready stays high.
// in_ch.ready drops while the queue has fewer than three free entries.
// synchronous active-low reset puts the parser at the start of a method field.
module http_request_byte_parser_top
  import hrbp_pkg::*;
#(
  parameter int unsigned RES_DEPTH = RQ_DEPTH  // power of two, at least 4
)
(
  input logic        clk,
  input logic        rst_n,
  hrbp_in_if.sink    in_ch,
  hrbp_out_if.source out_ch
);

  logic       acc;
  logic       has_room;
  logic       not_empty;
  logic       pop;
  logic [1:0] push_cnt;
  res_t       push_res [3];
  res_t       head;

  assign in_ch.ready = has_room;
  assign acc         = in_ch.valid && has_room;
  assign pop         = not_empty && out_ch.ready;

  hrbp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .push_cnt  (push_cnt),
    .push_res  (push_res)
  );

  hrbp_rq #(
    .DEPTH (RES_DEPTH)
  ) u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_res  (push_res),
    .pop       (pop),
    .not_empty (not_empty),
    .has_room  (has_room),
    .head      (head)
  );

  assign out_ch.valid        = not_empty;
  assign out_ch.kind         = head.kind;
  assign out_ch.raw_byte     = head.raw_byte;
  assign out_ch.lowered_byte = head.lowered_byte;
  assign out_ch.flag         = head.flag;
  assign out_ch.status       = head.status;
  assign out_ch.run_last     = head.run_last;

endmodule
